@@ rtl/core/superpixel_pixel_assignment_defines.svh @@
// Assertion macros for the superpixel pixel assignment block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef SUPERPIXEL_PIXEL_ASSIGNMENT_DEFINES_SVH
`define SUPERPIXEL_PIXEL_ASSIGNMENT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SPA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SPA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/spa_pkg.sv @@
// Shared types, widths and codes for the superpixel pixel assignment block.
// No dependencies.
package spa_pkg;

    localparam int MAX_CLUSTERS = 256;
    localparam int MAX_DIM      = 2048;

    localparam int SLOT_W   = 8;
    localparam int TBL_AW   = $clog2(MAX_CLUSTERS);
    localparam int CNT_W    = 9;
    localparam int COORD_W  = 11;
    localparam int COL_W    = 8;
    localparam int NCH      = 3;
    localparam int WGT_W    = 12;
    localparam int DIM_W    = 12;
    localparam int CHC_W    = 2;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int SQXY_W   = SQ_W + 1;
    localparam int SQC_W    = 2 * COL_W;
    localparam int CSUM_W   = SQC_W + 2;
    localparam int PROD_W   = WGT_W + SQXY_W;
    localparam int DIST_W   = 40;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_SPATIAL_WEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HALF_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HALF_Y   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CLUSTERS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd6;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic [DIST_W-1:0] DIST_ALL_ONES = '1;
    localparam logic [CNT_W-1:0]  CLUSTER_LIMIT = CNT_W'(MAX_CLUSTERS);
    localparam logic [DIM_W-1:0]  DIM_LIMIT     = DIM_W'(MAX_DIM);

    // cluster table entry, also used for the pixel under test
    typedef struct packed {
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [NCH*COL_W-1:0] colour;
    } entry_t;

    typedef struct packed {
        logic [WGT_W-1:0]   weight;
        logic [COORD_W-1:0] half_x;
        logic [COORD_W-1:0] half_y;
        logic [CHC_W-1:0]   channels;
    } dist_cfg_t;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [SLOT_W-1:0] idx;
    } cand_tag_t;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [SLOT_W-1:0] idx;
        logic [DIST_W-1:0] distance;
    } cand_t;

endpackage

@@ rtl/core/spa_dist_unit.sv @@
// Shared distance pipeline: window test and weighted squared distance, one slot per cycle.
// Depends on spa_pkg.
module spa_dist_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  spa_pkg::dist_cfg_t cfg_i,
    input  spa_pkg::entry_t    pixel_i,
    input  spa_pkg::cand_tag_t tag_i,
    input  spa_pkg::entry_t    entry_i,
    output spa_pkg::cand_t     cand_o,
    output logic               busy_o
);

    spa_pkg::cand_tag_t tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg;

    logic [spa_pkg::COORD_W-1:0] dx1_reg, dy1_reg;
    logic [spa_pkg::COL_W-1:0]   dc1_reg [spa_pkg::NCH];
    logic [spa_pkg::SQ_W-1:0]    sqx2_reg, sqy2_reg;
    logic [spa_pkg::SQC_W-1:0]   sqc2_reg [spa_pkg::NCH];
    logic [spa_pkg::SQXY_W-1:0]  sxy3_reg;
    logic [spa_pkg::CSUM_W-1:0]  csum3_reg, csum4_reg;
    logic [spa_pkg::PROD_W-1:0]  prod4_reg;
    logic [spa_pkg::DIST_W-1:0]  dist5_reg;

    logic [spa_pkg::COORD_W-1:0] dx, dy;
    logic [spa_pkg::COL_W-1:0]   dc [spa_pkg::NCH];
    logic                        in_window;

    always_comb begin
        dx = (pixel_i.x > entry_i.x) ? pixel_i.x - entry_i.x : entry_i.x - pixel_i.x;
        dy = (pixel_i.y > entry_i.y) ? pixel_i.y - entry_i.y : entry_i.y - pixel_i.y;
        in_window = (dx <= cfg_i.half_x) && (dy <= cfg_i.half_y);
        for (int u = 0; u < spa_pkg::NCH; u++) begin
            logic [spa_pkg::COL_W-1:0] pc, cc;
            pc = pixel_i.colour[u*spa_pkg::COL_W +: spa_pkg::COL_W];
            cc = entry_i.colour[u*spa_pkg::COL_W +: spa_pkg::COL_W];
            if (cfg_i.channels > spa_pkg::CHC_W'(u)) begin
                dc[u] = (pc > cc) ? pc - cc : cc - pc;
            end else begin
                dc[u] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
            tag5_reg <= '0;
        end else begin
            tag1_reg.valid <= tag_i.valid;
            tag1_reg.hit   <= tag_i.hit && in_window;
            tag1_reg.idx   <= tag_i.idx;
            tag2_reg       <= tag1_reg;
            tag3_reg       <= tag2_reg;
            tag4_reg       <= tag3_reg;
            tag5_reg       <= tag4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        dx1_reg  <= dx;
        dy1_reg  <= dy;
        sqx2_reg <= spa_pkg::SQ_W'(dx1_reg) * spa_pkg::SQ_W'(dx1_reg);
        sqy2_reg <= spa_pkg::SQ_W'(dy1_reg) * spa_pkg::SQ_W'(dy1_reg);
        for (int u = 0; u < spa_pkg::NCH; u++) begin
            dc1_reg[u]  <= dc[u];
            sqc2_reg[u] <= spa_pkg::SQC_W'(dc1_reg[u]) * spa_pkg::SQC_W'(dc1_reg[u]);
        end
        sxy3_reg  <= spa_pkg::SQXY_W'(sqx2_reg) + spa_pkg::SQXY_W'(sqy2_reg);
        csum3_reg <= spa_pkg::CSUM_W'(sqc2_reg[0]) + spa_pkg::CSUM_W'(sqc2_reg[1])
                   + spa_pkg::CSUM_W'(sqc2_reg[2]);
        prod4_reg <= spa_pkg::PROD_W'(cfg_i.weight) * spa_pkg::PROD_W'(sxy3_reg);
        csum4_reg <= csum3_reg;
        dist5_reg <= spa_pkg::DIST_W'(prod4_reg) + spa_pkg::DIST_W'(csum4_reg);
    end

    assign cand_o.valid    = tag5_reg.valid;
    assign cand_o.hit      = tag5_reg.hit;
    assign cand_o.idx      = tag5_reg.idx;
    assign cand_o.distance = dist5_reg;

    assign busy_o = tag1_reg.valid | tag2_reg.valid | tag3_reg.valid
                  | tag4_reg.valid | tag5_reg.valid;

endmodule

@@ rtl/core/superpixel_pixel_assignment.sv @@
// Top level of the superpixel pixel assignment block: cluster table, scan sequencer, result register.
// Depends on spa_pkg, spa_dist_unit and superpixel_pixel_assignment_defines.svh.
//
//  channel  | ports                                   | moves
//  ---------+-----------------------------------------+---------------------------------
//  input    | s_tvalid s_tready s_tdata[63:0] s_tuser | cluster load or pixel to classify
//  result   | m_tvalid m_tready m_tdata[47:0] m_tuser | label, distance and flags per pixel
//  config   | cfg_we cfg_index[2:0] cfg_wdata[11:0]   | register writes, no read-back
//
// A load transaction writes the table in IDLE. A pixel scans min(active_clusters, 256) slots:
// the table is read one slot per cycle into the shared five-stage distance pipeline.
// A pixel outside the image, or with no active clusters, skips the scan.
// Reset clears the live marks and restores the register defaults; no clearing pass.
// s_tready is low while a pixel is scanned; a finished result waits in the output
// register for m_tready while the next transaction may already be taken.
`include "superpixel_pixel_assignment_defines.svh"

module superpixel_pixel_assignment (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // slot[7:0] pos_x[18:8] pos_y[29:19] colour_a[37:30] colour_b[45:38]
    // colour_c[53:46] slot_valid[54] prior_label[62:55], bit 63 zero
    input  logic [63:0]                       s_tdata,
    // cmd[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // label[7:0] best_distance[47:8]
    output logic [47:0]                       m_tdata,
    // covered[0] out_of_range[1]
    output logic [1:0]                        m_tuser,
    input  logic                              cfg_we,
    input  logic [spa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [spa_pkg::WGT_W-1:0]   spatial_weight_reg;
    logic [spa_pkg::COORD_W-1:0] window_half_x_reg, window_half_y_reg;
    logic [spa_pkg::CHC_W-1:0]   channel_count_reg;
    logic [spa_pkg::CNT_W-1:0]   active_clusters_reg;
    logic [spa_pkg::DIM_W-1:0]   image_width_reg, image_height_reg;

    logic [spa_pkg::MAX_CLUSTERS-1:0] live_reg;
    spa_pkg::entry_t                  tbl_mem [spa_pkg::MAX_CLUSTERS];

    logic [1:0]                  state_reg;
    logic [spa_pkg::CNT_W-1:0]   k_reg, count_reg;
    spa_pkg::entry_t             pixel_reg, rd_entry_reg;
    spa_pkg::cand_tag_t          rd_tag_reg;
    logic [spa_pkg::DIST_W-1:0]  best_reg;
    logic [spa_pkg::SLOT_W-1:0]  label_reg;
    logic                        covered_reg, outside_reg;
    logic                        m_tvalid_reg;
    logic [47:0]                 m_tdata_reg;
    logic [1:0]                  m_tuser_reg;

    spa_pkg::dist_cfg_t          dist_cfg;
    spa_pkg::cand_t              cand;
    logic                        pipe_busy;

    logic                        s_accept;
    logic [spa_pkg::SLOT_W-1:0]  in_slot, in_prior;
    spa_pkg::entry_t             in_entry;
    logic                        in_live;
    logic [spa_pkg::DIM_W-1:0]   width_clip, height_clip;
    logic [spa_pkg::CNT_W-1:0]   count_clip;
    logic                        in_outside;
    logic                        out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign in_slot         = s_tdata[7:0];
    assign in_entry.x      = s_tdata[18:8];
    assign in_entry.y      = s_tdata[29:19];
    assign in_entry.colour = s_tdata[53:30];
    assign in_live         = s_tdata[54];
    assign in_prior        = s_tdata[62:55];

    assign width_clip  = (image_width_reg > spa_pkg::DIM_LIMIT) ? spa_pkg::DIM_LIMIT
                                                                 : image_width_reg;
    assign height_clip = (image_height_reg > spa_pkg::DIM_LIMIT) ? spa_pkg::DIM_LIMIT
                                                                  : image_height_reg;
    assign count_clip  = (active_clusters_reg > spa_pkg::CLUSTER_LIMIT) ? spa_pkg::CLUSTER_LIMIT
                                                                         : active_clusters_reg;
    assign in_outside  = (spa_pkg::DIM_W'(in_entry.x) >= width_clip)
                      || (spa_pkg::DIM_W'(in_entry.y) >= height_clip);

    assign out_free = !m_tvalid_reg || m_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spatial_weight_reg  <= spa_pkg::WGT_W'(30);
            window_half_x_reg   <= spa_pkg::COORD_W'(32);
            window_half_y_reg   <= spa_pkg::COORD_W'(32);
            channel_count_reg   <= spa_pkg::CHC_W'(3);
            active_clusters_reg <= '0;
            image_width_reg     <= spa_pkg::DIM_W'(640);
            image_height_reg    <= spa_pkg::DIM_W'(480);
        end else if (cfg_we) begin
            case (cfg_index)
                spa_pkg::REG_SPATIAL_WEIGHT:  spatial_weight_reg  <= cfg_wdata;
                spa_pkg::REG_WINDOW_HALF_X:   window_half_x_reg   <= cfg_wdata[10:0];
                spa_pkg::REG_WINDOW_HALF_Y:   window_half_y_reg   <= cfg_wdata[10:0];
                spa_pkg::REG_CHANNEL_COUNT:   channel_count_reg   <= cfg_wdata[1:0];
                spa_pkg::REG_ACTIVE_CLUSTERS: active_clusters_reg <= cfg_wdata[8:0];
                spa_pkg::REG_IMAGE_WIDTH:     image_width_reg     <= cfg_wdata;
                spa_pkg::REG_IMAGE_HEIGHT:    image_height_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // cluster table: registered read at the scan index
    always_ff @(posedge aclk) begin
        if (s_accept && s_tuser == spa_pkg::CMD_LOAD
            && spa_pkg::CNT_W'(in_slot) < spa_pkg::CLUSTER_LIMIT) begin
            tbl_mem[in_slot[spa_pkg::TBL_AW-1:0]] <= in_entry;
        end
        rd_entry_reg <= tbl_mem[k_reg[spa_pkg::TBL_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg   <= '0;
            rd_tag_reg <= '0;
        end else begin
            if (s_accept && s_tuser == spa_pkg::CMD_LOAD
                && spa_pkg::CNT_W'(in_slot) < spa_pkg::CLUSTER_LIMIT) begin
                live_reg[in_slot[spa_pkg::TBL_AW-1:0]] <= in_live;
            end
            rd_tag_reg.valid <= (state_reg == ST_SCAN);
            rd_tag_reg.hit   <= live_reg[k_reg[spa_pkg::TBL_AW-1:0]];
            rd_tag_reg.idx   <= k_reg[spa_pkg::SLOT_W-1:0];
        end
    end

    assign dist_cfg.weight   = spatial_weight_reg;
    assign dist_cfg.half_x   = window_half_x_reg;
    assign dist_cfg.half_y   = window_half_y_reg;
    assign dist_cfg.channels = channel_count_reg;

    spa_dist_unit u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_i   (dist_cfg),
        .pixel_i (pixel_reg),
        .tag_i   (rd_tag_reg),
        .entry_i (rd_entry_reg),
        .cand_o  (cand),
        .busy_o  (pipe_busy)
    );

    // scan sequencer and running minimum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept && s_tuser == spa_pkg::CMD_PIXEL) begin
                        k_reg <= '0;
                        if (in_outside || count_clip == '0) begin
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == count_reg - 1'b1) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!rd_tag_reg.valid && !pipe_busy) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_tuser == spa_pkg::CMD_PIXEL) begin
            pixel_reg   <= in_entry;
            count_reg   <= count_clip;
            outside_reg <= in_outside;
            label_reg   <= in_prior;
            best_reg    <= spa_pkg::DIST_ALL_ONES;
            covered_reg <= 1'b0;
        end else if (cand.valid && cand.hit) begin
            covered_reg <= 1'b1;
            if (cand.distance < best_reg) begin
                best_reg  <= cand.distance;
                label_reg <= cand.idx;
            end
        end
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= {best_reg, label_reg};
            m_tuser_reg <= {outside_reg, covered_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `SPA_ASSERT_NOW(a_oor_not_covered, aclk, aresetn, m_tvalid_reg && m_tuser_reg[1], !m_tuser_reg[0], "out-of-range pixel reported as covered")
    `SPA_ASSERT_NOW(a_uncovered_dist, aclk, aresetn, m_tvalid_reg && !m_tuser_reg[0], m_tdata_reg[47:8] == spa_pkg::DIST_ALL_ONES, "uncovered pixel without all-ones distance")
    `SPA_ASSERT_NOW(a_cand_in_scan, aclk, aresetn, cand.valid, state_reg == ST_SCAN || state_reg == ST_DRAIN, "distance candidate outside a scan")
    `SPA_ASSERT_NEXT(a_done_holds, aclk, aresetn, state_reg == ST_DONE && m_tvalid_reg && !m_tready, state_reg == ST_DONE, "result overwrote a pending transaction")

endmodule

@@ tb/sv/superpixel_pixel_assignment_tb.sv @@
// Self-checking testbench for superpixel_pixel_assignment: cluster loads and pixel
// classification, checked against a local nearest-cluster predictor.
// Depends on spa_pkg and the superpixel_pixel_assignment RTL.
module superpixel_pixel_assignment_tb;

    localparam int TAIL_CYCLES  = 32;
    localparam int PHASES       = 14;
    localparam int PHASE_ITEMS  = 78;
    // worst case ~1400 transactions, each with a full table scan and stalls, several times over
    localparam longint LIMIT_CYCLES = 2000000;

    typedef struct packed {
        logic               cmd;
        logic [7:0]         slot;
        logic [10:0]        x;
        logic [10:0]        y;
        logic [23:0]        colour;   // a in 7:0, b in 15:8, c in 23:16
        logic               live;
        logic [7:0]         prior;
    } request_t;

    typedef struct packed {
        logic [7:0]                 label;
        logic [spa_pkg::DIST_W-1:0] distance;
        logic                       covered;
        logic                       outside;
    } assignment_t;

    typedef struct {
        bit                              is_cfg;
        logic [spa_pkg::CFG_IDX_W-1:0]   idx;
        int                              val;
        request_t                        req;
        bit                              fixed;
        assignment_t                     want;
    } plan_row_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [63:0]                      s_tdata = '0;
    logic                             s_tuser = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [47:0]                      m_tdata;
    logic [1:0]                       m_tuser;
    logic                             cfg_we = 1'b0;
    logic [spa_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [spa_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

    // predictor copy of the registers and the cluster table
    int unsigned             weight, half_x, half_y, channels, active, img_w, img_h;
    logic [10:0]             centre_x [spa_pkg::MAX_CLUSTERS];
    logic [10:0]             centre_y [spa_pkg::MAX_CLUSTERS];
    logic [23:0]             centre_colour [spa_pkg::MAX_CLUSTERS];
    logic                    centre_live [spa_pkg::MAX_CLUSTERS];

    assignment_t             pending_assignments [$];
    plan_row_t               plan [$];
    int                      fault_count = 0;
    longint                  cycle_count = 0;
    bit                      bursts_on = 1'b0;

    superpixel_pixel_assignment uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL superpixel_pixel_assignment");
            $finish;
        end
    end

    task automatic flag(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fault_count++;
    endtask

    function automatic int unsigned absdiff(input int unsigned p, input int unsigned q);
        return (p > q) ? p - q : q - p;
    endfunction

    function automatic assignment_t assign_pixel(input request_t r);
        assignment_t a;
        int unsigned w, h, span, dx, dy, dc;
        logic [63:0] d;
        a.label    = r.prior;
        a.distance = spa_pkg::DIST_ALL_ONES;
        a.covered  = 1'b0;
        w = (img_w > spa_pkg::MAX_DIM) ? spa_pkg::MAX_DIM : img_w;
        h = (img_h > spa_pkg::MAX_DIM) ? spa_pkg::MAX_DIM : img_h;
        a.outside = (r.x >= w) || (r.y >= h);
        if (!a.outside) begin
            span = (active > spa_pkg::MAX_CLUSTERS) ? spa_pkg::MAX_CLUSTERS : active;
            for (int k = 0; k < span; k++) begin
                if (!centre_live[k]) continue;
                dx = absdiff(r.x, centre_x[k]);
                dy = absdiff(r.y, centre_y[k]);
                if (dx > half_x || dy > half_y) continue;
                a.covered = 1'b1;
                d = 64'(weight) * 64'(dx * dx + dy * dy);
                for (int c = 0; c < channels && c < spa_pkg::NCH; c++) begin
                    dc = absdiff(r.colour[8*c +: 8], centre_colour[k][8*c +: 8]);
                    d += 64'(dc * dc);
                end
                if (d < 64'(a.distance)) begin
                    a.distance = d[spa_pkg::DIST_W-1:0];
                    a.label    = 8'(k);
                end
            end
        end
        return a;
    endfunction

    function automatic request_t make_request(input logic cmd, input int slot, input int x,
                                              input int y, input logic [23:0] colour,
                                              input logic live, input int prior);
        request_t r;
        r.cmd    = cmd;
        r.slot   = 8'(slot);
        r.x      = 11'(x);
        r.y      = 11'(y);
        r.colour = colour;
        r.live   = live;
        r.prior  = 8'(prior);
        return r;
    endfunction

    function automatic plan_row_t cfg_row(input logic [spa_pkg::CFG_IDX_W-1:0] idx,
                                          input int val);
        plan_row_t p;
        p = '{default: '0};
        p.is_cfg = 1'b1;
        p.idx    = idx;
        p.val    = val;
        return p;
    endfunction

    function automatic plan_row_t load_row(input int slot, input int x, input int y,
                                           input logic [23:0] colour, input logic live);
        plan_row_t p;
        p = '{default: '0};
        p.req = make_request(spa_pkg::CMD_LOAD, slot, x, y, colour, live, 0);
        return p;
    endfunction

    function automatic plan_row_t pixel_row(input int x, input int y,
                                            input logic [23:0] colour, input int prior);
        plan_row_t p;
        p = '{default: '0};
        p.req = make_request(spa_pkg::CMD_PIXEL, 0, x, y, colour, 1'b0, prior);
        return p;
    endfunction

    function automatic plan_row_t known_pixel(input int x, input int y,
                                              input logic [23:0] colour, input int prior,
                                              input int label,
                                              input logic [spa_pkg::DIST_W-1:0] best,
                                              input logic covered, input logic outside);
        plan_row_t p;
        p = pixel_row(x, y, colour, prior);
        p.fixed = 1'b1;
        p.want  = '{label: 8'(label), distance: best, covered: covered, outside: outside};
        return p;
    endfunction

    task automatic add_row(input plan_row_t p);
        plan = {plan, p};
    endtask

    task automatic write_reg(input logic [spa_pkg::CFG_IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= spa_pkg::CFG_DATA_W'(val);
        @(posedge aclk);
        case (idx)
            spa_pkg::REG_SPATIAL_WEIGHT:  weight   = val & 12'hFFF;
            spa_pkg::REG_WINDOW_HALF_X:   half_x   = val & 11'h7FF;
            spa_pkg::REG_WINDOW_HALF_Y:   half_y   = val & 11'h7FF;
            spa_pkg::REG_CHANNEL_COUNT:   channels = val & 2'h3;
            spa_pkg::REG_ACTIVE_CLUSTERS: active   = val & 9'h1FF;
            spa_pkg::REG_IMAGE_WIDTH:     img_w    = val & 12'hFFF;
            spa_pkg::REG_IMAGE_HEIGHT:    img_h    = val & 12'hFFF;
            default: ;
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_assignments.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic push_item(input request_t r, input bit fixed, input assignment_t want);
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tdata  <= {1'b0, r.prior, r.live, r.colour, r.y, r.x, r.slot};
        do @(posedge aclk); while (!s_tready);
        if (r.cmd == spa_pkg::CMD_LOAD) begin
            centre_x[r.slot]      = r.x;
            centre_y[r.slot]      = r.y;
            centre_colour[r.slot] = r.colour;
            centre_live[r.slot]   = r.live;
        end else begin
            pending_assignments = {pending_assignments, fixed ? want : assign_pixel(r)};
        end
    endtask

    // result side back-pressure
    initial begin
        forever begin
            @(posedge aclk);
            if (bursts_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        assignment_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_assignments.size() == 0) begin
                flag($sformatf("unexpected result label %0d", m_tdata[7:0]));
            end else begin
                want = pending_assignments.pop_front();
                if (m_tdata[7:0] !== want.label)
                    flag($sformatf("label got %0d want %0d", m_tdata[7:0], want.label));
                if (m_tdata[47:8] !== want.distance)
                    flag($sformatf("best_distance got %0h want %0h", m_tdata[47:8],
                                   want.distance));
                if (m_tuser[0] !== want.covered)
                    flag($sformatf("covered got %b want %b", m_tuser[0], want.covered));
                if (m_tuser[1] !== want.outside)
                    flag($sformatf("out_of_range got %b want %b", m_tuser[1], want.outside));
            end
        end
    end

    initial begin
        request_t    r;
        int unsigned span, dim_x, dim_y, rx, ry, lead;
        int          px, py, k;
        logic [23:0] col;

        weight = 30; half_x = 32; half_y = 32; channels = 3;
        active = 0; img_w = 640; img_h = 480;
        foreach (centre_live[i]) centre_live[i] = 1'b0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // preload every slot as dead so no scan ever reads an unwritten entry
        bursts_on = 1'b1;
        for (int s = 0; s < spa_pkg::MAX_CLUSTERS; s++) begin
            r = make_request(spa_pkg::CMD_LOAD, s, $urandom_range(0, 2047),
                             $urandom_range(0, 2047), 24'($urandom), 1'b0, 0);
            push_item(r, 1'b0, '0);
        end

        // reset settings, nothing scanned
        add_row(known_pixel(0, 0, 24'h000000, 8'h5A, 8'h5A, spa_pkg::DIST_ALL_ONES, 0, 0));
        add_row(known_pixel(639, 479, 24'hFFFFFF, 8'hFF, 8'hFF, spa_pkg::DIST_ALL_ONES, 0, 0));
        add_row(known_pixel(640, 0, 24'h123456, 8'h00, 8'h00, spa_pkg::DIST_ALL_ONES, 0, 1));
        add_row(known_pixel(0, 480, 24'h654321, 8'h3C, 8'h3C, spa_pkg::DIST_ALL_ONES, 0, 1));
        add_row(known_pixel(2047, 2047, 24'hA5A5A5, 8'h81, 8'h81, spa_pkg::DIST_ALL_ONES,
                            0, 1));
        // tie on equal centres, dead slot, window edge
        add_row(cfg_row(spa_pkg::REG_ACTIVE_CLUSTERS, 256));
        add_row(load_row(0, 100, 100, 24'h1E140A, 1'b1));
        add_row(load_row(1, 100, 100, 24'h1E140A, 1'b1));
        add_row(load_row(255, 2047, 2047, 24'hFFFFFF, 1'b1));
        add_row(load_row(2, 100, 101, 24'h1E140A, 1'b0));
        add_row(known_pixel(100, 100, 24'h1E140A, 7, 0, '0, 1, 0));
        add_row(pixel_row(132, 68, 24'h1EFF00, 1));
        add_row(known_pixel(133, 100, 24'h000000, 9, 9, spa_pkg::DIST_ALL_ONES, 0, 0));
        // extremes: oversized image, widest windows, largest weight
        add_row(cfg_row(spa_pkg::REG_IMAGE_WIDTH, 4095));
        add_row(cfg_row(spa_pkg::REG_IMAGE_HEIGHT, 4095));
        add_row(cfg_row(spa_pkg::REG_WINDOW_HALF_X, 2047));
        add_row(cfg_row(spa_pkg::REG_WINDOW_HALF_Y, 2047));
        add_row(cfg_row(spa_pkg::REG_SPATIAL_WEIGHT, 4095));
        add_row(known_pixel(2047, 2047, 24'hFFFFFF, 0, 255, '0, 1, 0));
        add_row(load_row(0, 0, 0, 24'h000000, 1'b0));
        add_row(load_row(1, 0, 0, 24'h000000, 1'b0));
        add_row(pixel_row(0, 0, 24'h000000, 0));
        add_row(cfg_row(spa_pkg::REG_CHANNEL_COUNT, 0));
        add_row(pixel_row(0, 0, 24'h000000, 2));
        add_row(cfg_row(spa_pkg::REG_CHANNEL_COUNT, 1));
        add_row(pixel_row(2047, 2040, 24'h000000, 3));
        // zero weight and zero windows: centre only
        add_row(cfg_row(spa_pkg::REG_SPATIAL_WEIGHT, 0));
        add_row(cfg_row(spa_pkg::REG_WINDOW_HALF_X, 0));
        add_row(cfg_row(spa_pkg::REG_WINDOW_HALF_Y, 0));
        add_row(known_pixel(2047, 2047, 24'h0000FF, 5, 255, '0, 1, 0));
        add_row(known_pixel(2047, 2046, 24'h0000FF, 4, 4, spa_pkg::DIST_ALL_ONES, 0, 0));
        add_row(cfg_row(spa_pkg::REG_IMAGE_WIDTH, 0));
        add_row(known_pixel(0, 0, 24'h000000, 6, 6, spa_pkg::DIST_ALL_ONES, 0, 1));

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                drain();
                write_reg(plan[i].idx, plan[i].val);
                cfg_we <= 1'b0;
            end else begin
                push_item(plan[i].req, plan[i].fixed, plan[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            bursts_on = (ph % 4 != 3) && (ph < PHASES - 2);
            write_reg(spa_pkg::REG_SPATIAL_WEIGHT, ($urandom_range(0, 3) == 0) ?
                      (($urandom_range(0, 1) == 0) ? 0 : 4095) : $urandom_range(0, 4095));
            case ($urandom_range(0, 3))
                0:       write_reg(spa_pkg::REG_WINDOW_HALF_X, $urandom_range(0, 2047));
                1:       write_reg(spa_pkg::REG_WINDOW_HALF_X, $urandom_range(0, 8));
                default: write_reg(spa_pkg::REG_WINDOW_HALF_X, $urandom_range(1, 48));
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(spa_pkg::REG_WINDOW_HALF_Y, $urandom_range(0, 2047));
                1:       write_reg(spa_pkg::REG_WINDOW_HALF_Y, $urandom_range(0, 8));
                default: write_reg(spa_pkg::REG_WINDOW_HALF_Y, $urandom_range(1, 48));
            endcase
            write_reg(spa_pkg::REG_CHANNEL_COUNT, $urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:       write_reg(spa_pkg::REG_ACTIVE_CLUSTERS, 256);
                1:       write_reg(spa_pkg::REG_ACTIVE_CLUSTERS, $urandom_range(257, 511));
                2:       write_reg(spa_pkg::REG_ACTIVE_CLUSTERS, 0);
                3, 4, 5: write_reg(spa_pkg::REG_ACTIVE_CLUSTERS, $urandom_range(1, 16));
                default: write_reg(spa_pkg::REG_ACTIVE_CLUSTERS, $urandom_range(17, 80));
            endcase
            for (int d = 0; d < 2; d++) begin
                case ($urandom_range(0, 7))
                    0:       px = $urandom_range(0, 64);
                    1:       px = $urandom_range(2049, 4095);
                    2:       px = 2048;
                    default: px = $urandom_range(64, 2048);
                endcase
                write_reg((d == 0) ? spa_pkg::REG_IMAGE_WIDTH : spa_pkg::REG_IMAGE_HEIGHT, px);
            end
            cfg_we <= 1'b0;

            span  = (active > spa_pkg::MAX_CLUSTERS) ? spa_pkg::MAX_CLUSTERS : active;
            dim_x = (img_w > spa_pkg::MAX_DIM) ? spa_pkg::MAX_DIM : ((img_w == 0) ? 1 : img_w);
            dim_y = (img_h > spa_pkg::MAX_DIM) ? spa_pkg::MAX_DIM : ((img_h == 0) ? 1 : img_h);
            rx    = half_x + 2;
            ry    = half_y + 2;
            lead  = $urandom_range(2, 10);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n < lead || $urandom_range(0, 4) == 0) begin
                    k = (span > 0) ? $urandom_range(0, span - 1) : $urandom_range(0, 255);
                    r = make_request(spa_pkg::CMD_LOAD, k, $urandom_range(0, dim_x - 1),
                                     $urandom_range(0, dim_y - 1), 24'($urandom),
                                     $urandom_range(0, 3) != 0, $urandom_range(0, 255));
                end else begin
                    if (span > 0 && $urandom_range(0, 3) != 0) begin
                        k  = $urandom_range(0, span - 1);
                        px = int'(centre_x[k]) + int'($urandom_range(0, 2 * rx)) - int'(rx);
                        py = int'(centre_y[k]) + int'($urandom_range(0, 2 * ry)) - int'(ry);
                        px = (px < 0) ? 0 : ((px > 2047) ? 2047 : px);
                        py = (py < 0) ? 0 : ((py > 2047) ? 2047 : py);
                        col = 24'($urandom);
                        if ($urandom_range(0, 1) == 0) begin
                            for (int c = 0; c < spa_pkg::NCH; c++) begin
                                col[8*c +: 8] = 8'(int'(centre_colour[k][8*c +: 8])
                                                   + int'($urandom_range(0, 16)) - 8);
                            end
                        end
                    end else begin
                        px  = $urandom_range(0, 2047);
                        py  = $urandom_range(0, 2047);
                        col = 24'($urandom);
                    end
                    r = make_request(spa_pkg::CMD_PIXEL, $urandom_range(0, 255), px, py, col,
                                     $urandom_range(0, 1), $urandom_range(0, 255));
                end
                push_item(r, 1'b0, '0);
            end
        end

        drain();
        if (fault_count == 0) begin
            $display("PASS superpixel_pixel_assignment");
        end else begin
            $display("FAIL superpixel_pixel_assignment");
        end
        $finish;
    end

endmodule
